>>> design/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, token codes and character classes for the source tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int POS_W = 32;
  localparam int MAX_NUM_TEXT = 64;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [3:0] TK_EOF    = 4'd0;
  localparam logic [3:0] TK_INT    = 4'd1;
  localparam logic [3:0] TK_FLOAT  = 4'd2;
  localparam logic [3:0] TK_IMAG   = 4'd3;
  localparam logic [3:0] TK_STRING = 4'd4;
  localparam logic [3:0] TK_OP     = 4'd5;
  localparam logic [3:0] TK_PUNCT  = 4'd6;
  localparam logic [3:0] TK_IDENT  = 4'd7;
  localparam logic [3:0] TK_ERROR  = 4'd8;

  localparam logic [1:0] RAD_HEX = 2'd1;
  localparam logic [1:0] RAD_OCT = 2'd2;
  localparam logic [1:0] RAD_BIN = 2'd3;

  localparam int FL_FLOAT = 0;
  localparam int FL_IMAG  = 1;

  typedef enum logic [3:0] {
    M_IDLE, M_HOLD, M_RADIX, M_STRING, M_IDENT,
    M_INT, M_DOT, M_FRAC, M_EXP0, M_EXP1
  } mode_t;

  typedef struct packed {
    logic [3:0]       ttype;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
    logic [63:0]      value;
    logic             last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return is_letter(b) || b == "_" || b == "$";
  endfunction

  function automatic logic is_suffix(input logic [7:0] b);
    return b == "$" || b == "%" || b == "&" || b == "!" || b == "#" || b == "~";
  endfunction

  function automatic logic is_exp(input logic [7:0] b);
    return b == "E" || b == "e" || b == "D" || b == "d";
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] t, input logic [POS_W-1:0] s,
                                  input logic [POS_W-1:0] l, input logic [63:0] v);
    tok_t r;
    r.ttype = t;
    r.start = s;
    r.len   = l;
    r.value = v;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic tok_t num_tok(input logic [3:0] fl, input logic [POS_W-1:0] ts,
                                   input logic [POS_W-1:0] endp, input logic [63:0] acc);
    logic [POS_W-1:0] l;
    l = endp - ts;
    if (fl[FL_IMAG]) return mk_tok(TK_IMAG, ts, l, 64'd0);
    else if (l >= POS_W'(MAX_NUM_TEXT)) return mk_tok(TK_ERROR, ts, l, 64'd0);
    else if (fl[FL_FLOAT]) return mk_tok(TK_FLOAT, ts, l, 64'd0);
    else return mk_tok(TK_INT, ts, l, acc);
  endfunction

  // {valid, digit}
  function automatic logic [4:0] radix_digit(input logic [1:0] rs, input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (rs == RAD_HEX) begin
      if (is_digit(b)) return {1'b1, 4'(b - "0")};
      if (b >= "A" && b <= "F") begin
        d = b - "A" + 8'd10;
        return {1'b1, d[3:0]};
      end
      if (b >= "a" && b <= "f") begin
        d = b - "a" + 8'd10;
        return {1'b1, d[3:0]};
      end
      return 5'd0;
    end
    if (rs == RAD_OCT) return (b >= "0" && b <= "7") ? {1'b1, 4'(b - "0")} : 5'd0;
    return (b == "0" || b == "1") ? {1'b1, 4'(b - "0")} : 5'd0;
  endfunction

endpackage

>>> design/bst_scan.sv
// ----------------------------------------------------------------------------
// bst_scan
// Scanner state and per-byte token decision; produces up to three tokens.
// ----------------------------------------------------------------------------
module bst_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               kind,
  input  logic [7:0]         char_code,
  output logic [1:0]         tok_count,
  output bst_pkg::tok_t      toks [3]
);

  bst_pkg::mode_t             mode, mode_next;
  logic [bst_pkg::POS_W-1:0]  pos, pos_next;
  logic [bst_pkg::POS_W-1:0]  tstart, tstart_next;
  logic [63:0]                acc, acc_next;
  logic [7:0]                 hb, hb_next;
  logic                       hv, hv_next;
  logic [3:0]                 fl, fl_next;
  logic [1:0]                 rs, rs_next;

  always_comb begin
    logic [bst_pkg::POS_W-1:0] p;
    logic [7:0]  b;
    logic        again, do_num, handled;
    logic [4:0]  rd;
    logic [67:0] wide;
    logic [1:0]  n;
    p = pos;
    b = char_code;
    again = 1'b0;
    do_num = 1'b0;
    handled = 1'b0;
    rd = 5'd0;
    wide = 68'd0;
    n = 2'd0;
    mode_next = mode;
    pos_next = pos;
    tstart_next = tstart;
    acc_next = acc;
    hb_next = hb;
    hv_next = hv;
    fl_next = fl;
    rs_next = rs;
    for (int k = 0; k < 3; k++) toks[k] = '0;

    if (kind) begin
      unique case (mode)
        bst_pkg::M_HOLD: begin
          toks[n] = bst_pkg::mk_tok(hb == ":" ? bst_pkg::TK_PUNCT : bst_pkg::TK_OP,
                                    tstart, 32'd1, 64'd0);
          n = n + 2'd1;
        end
        bst_pkg::M_RADIX: begin
          toks[n] = bst_pkg::mk_tok(bst_pkg::TK_INT, tstart, p - tstart, acc);
          n = n + 2'd1;
        end
        bst_pkg::M_STRING: begin
          toks[n] = bst_pkg::mk_tok(bst_pkg::TK_STRING, tstart, p - tstart, 64'd0);
          n = n + 2'd1;
        end
        bst_pkg::M_IDENT: begin
          toks[n] = bst_pkg::mk_tok(bst_pkg::TK_IDENT, tstart, p - tstart, 64'd0);
          n = n + 2'd1;
        end
        bst_pkg::M_DOT: begin
          toks[n] = bst_pkg::num_tok(fl | 4'b0001, tstart, p, acc);
          n = n + 2'd1;
        end
        bst_pkg::M_INT, bst_pkg::M_FRAC, bst_pkg::M_EXP0, bst_pkg::M_EXP1: begin
          toks[n] = bst_pkg::num_tok(fl, tstart, p, acc);
          n = n + 2'd1;
        end
        default: ;
      endcase
      toks[n] = bst_pkg::mk_tok(bst_pkg::TK_EOF, p, 32'd0, 64'd0);
      n = n + 2'd1;
      mode_next = bst_pkg::M_IDLE;
      pos_next = '0;
      tstart_next = '0;
      acc_next = '0;
      hb_next = '0;
      hv_next = 1'b0;
      fl_next = '0;
      rs_next = '0;
    end else begin
      unique case (mode)
        bst_pkg::M_HOLD: begin
          if (hb == "&" && (b == "H" || b == "h" || b == "O" || b == "o" ||
                            b == "B" || b == "b")) begin
            rs_next = (b == "H" || b == "h") ? bst_pkg::RAD_HEX :
                      (b == "O" || b == "o") ? bst_pkg::RAD_OCT : bst_pkg::RAD_BIN;
            acc_next = '0;
            hv_next = 1'b0;
            mode_next = bst_pkg::M_RADIX;
          end else if ((hb == "<" && (b == "=" || b == ">")) ||
                       (hb == ">" && (b == "=" || b == ">")) ||
                       (hb == ":" && b == ":")) begin
            toks[n] = bst_pkg::mk_tok(bst_pkg::TK_OP, tstart, 32'd2, 64'd0);
            n = n + 2'd1;
            hv_next = 1'b0;
            mode_next = bst_pkg::M_IDLE;
          end else begin
            toks[n] = bst_pkg::mk_tok(hb == ":" ? bst_pkg::TK_PUNCT : bst_pkg::TK_OP,
                                      tstart, 32'd1, 64'd0);
            n = n + 2'd1;
            hv_next = 1'b0;
            mode_next = bst_pkg::M_IDLE;
            again = 1'b1;
          end
        end
        bst_pkg::M_RADIX: begin
          rd = bst_pkg::radix_digit(rs, b);
          if (rd[4]) begin
            if (rs == bst_pkg::RAD_HEX) acc_next = {acc[59:0], rd[3:0]};
            else if (rs == bst_pkg::RAD_OCT) acc_next = {acc[60:0], rd[2:0]};
            else acc_next = {acc[62:0], rd[0]};
          end else begin
            toks[n] = bst_pkg::mk_tok(bst_pkg::TK_INT, tstart, p - tstart, acc);
            n = n + 2'd1;
            mode_next = bst_pkg::M_IDLE;
            again = 1'b1;
          end
        end
        bst_pkg::M_STRING: begin
          if (b == "\"" || b == 8'h0A) begin
            toks[n] = bst_pkg::mk_tok(bst_pkg::TK_STRING, tstart, p - tstart, 64'd0);
            n = n + 2'd1;
            mode_next = bst_pkg::M_IDLE;
            again = (b == 8'h0A);
          end
        end
        bst_pkg::M_IDENT: begin
          if (!(bst_pkg::is_alpha(b) || bst_pkg::is_digit(b))) begin
            if (bst_pkg::is_suffix(b)) begin
              toks[n] = bst_pkg::mk_tok(bst_pkg::TK_IDENT, tstart, p + 32'd1 - tstart,
                                        64'd0);
            end else begin
              toks[n] = bst_pkg::mk_tok(bst_pkg::TK_IDENT, tstart, p - tstart, 64'd0);
              again = 1'b1;
            end
            n = n + 2'd1;
            mode_next = bst_pkg::M_IDLE;
          end
        end
        bst_pkg::M_DOT: begin
          hv_next = 1'b0;
          if (bst_pkg::is_letter(b)) begin
            toks[n] = bst_pkg::num_tok(fl, tstart, p - 32'd1, acc);
            n = n + 2'd1;
            toks[n] = bst_pkg::mk_tok(bst_pkg::TK_PUNCT, p - 32'd1, 32'd1, 64'd0);
            n = n + 2'd1;
            mode_next = bst_pkg::M_IDLE;
            again = 1'b1;
          end else begin
            fl_next = fl | 4'b0001;
            mode_next = bst_pkg::M_FRAC;
            do_num = 1'b1;
          end
        end
        bst_pkg::M_INT, bst_pkg::M_FRAC, bst_pkg::M_EXP0, bst_pkg::M_EXP1: begin
          do_num = 1'b1;
        end
        default: again = 1'b1;
      endcase

      if (do_num) begin
        if (b == "i") begin
          fl_next = fl_next | 4'b0010;
          toks[n] = bst_pkg::num_tok(fl_next, tstart, p + 32'd1, acc);
          n = n + 2'd1;
          mode_next = bst_pkg::M_IDLE;
        end else begin
          if (mode_next == bst_pkg::M_INT) begin
            if (bst_pkg::is_digit(b)) begin
              wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + 68'(b - "0");
              acc_next = (wide > {4'd0, bst_pkg::SAT_MAX}) ? bst_pkg::SAT_MAX : wide[63:0];
              handled = 1'b1;
            end else if (b == ".") begin
              hb_next = b;
              hv_next = 1'b1;
              mode_next = bst_pkg::M_DOT;
              handled = 1'b1;
            end
          end else if (mode_next == bst_pkg::M_FRAC || mode_next == bst_pkg::M_EXP1) begin
            handled = bst_pkg::is_digit(b);
          end else if (bst_pkg::is_digit(b) || b == "+" || b == "-") begin
            mode_next = bst_pkg::M_EXP1;
            handled = 1'b1;
          end
          if (!handled && (mode_next == bst_pkg::M_INT || mode_next == bst_pkg::M_FRAC) &&
              bst_pkg::is_exp(b)) begin
            fl_next = fl_next | 4'b0001;
            mode_next = bst_pkg::M_EXP0;
            handled = 1'b1;
          end
          if (!handled) begin
            toks[n] = bst_pkg::num_tok(fl_next, tstart, p, acc);
            n = n + 2'd1;
            mode_next = bst_pkg::M_IDLE;
            again = 1'b1;
          end
        end
      end

      if (again) begin
        tstart_next = p;
        if (b == " " || b == 8'h09 || b == 8'h0D) begin
        end else if (b == "&" || b == "<" || b == ">" || b == ":") begin
          hb_next = b;
          hv_next = 1'b1;
          mode_next = bst_pkg::M_HOLD;
        end else if (b == "\"") begin
          tstart_next = p + 32'd1;
          mode_next = bst_pkg::M_STRING;
        end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "=" ||
                     b == "^" || b == "\\" || b == "|") begin
          toks[n] = bst_pkg::mk_tok(bst_pkg::TK_OP, p, 32'd1, 64'd0);
          n = n + 2'd1;
        end else if (b == "(" || b == ")" || b == "," || b == ";" || b == "#" ||
                     b == "@" || b == ".") begin
          toks[n] = bst_pkg::mk_tok(bst_pkg::TK_PUNCT, p, 32'd1, 64'd0);
          n = n + 2'd1;
        end else if (bst_pkg::is_digit(b)) begin
          acc_next = 64'(b - "0");
          fl_next = '0;
          mode_next = bst_pkg::M_INT;
        end else if (bst_pkg::is_alpha(b)) begin
          mode_next = bst_pkg::M_IDENT;
        end else begin
          toks[n] = bst_pkg::mk_tok(bst_pkg::TK_ERROR, p, 32'd1, 64'd0);
          n = n + 2'd1;
        end
      end
      pos_next = p + 32'd1;
    end

    if (n != 2'd0) toks[n - 2'd1].last = 1'b1;
    tok_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bst_pkg::M_IDLE;
      pos <= '0;
      tstart <= '0;
      acc <= '0;
      hb <= '0;
      hv <= 1'b0;
      fl <= '0;
      rs <= '0;
    end else if (fire) begin
      mode <= mode_next;
      pos <= pos_next;
      tstart <= tstart_next;
      acc <= acc_next;
      hb <= hb_next;
      hv <= hv_next;
      fl <= fl_next;
      rs <= rs_next;
    end
  end

endmodule

>>> design/bst_fifo.sv
// ----------------------------------------------------------------------------
// bst_fifo
// Token queue: takes up to three tokens per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module bst_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [1:0]     push_count,
  input  bst_pkg::tok_t  push_toks [3],
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output bst_pkg::tok_t  out_tok
);

  bst_pkg::tok_t                 mem [bst_pkg::FIFO_DEPTH];
  logic [bst_pkg::FIFO_AW-1:0]   wp, rp;
  logic [bst_pkg::FIFO_AW:0]     count, count_next;
  logic                          pop;
  logic [1:0]                    added;

  assign pop = out_valid && out_ready;
  assign added = push ? push_count : 2'd0;
  assign out_valid = count != '0;
  assign out_tok = mem[rp];
  assign room = count <= (bst_pkg::FIFO_AW + 1)'(bst_pkg::FIFO_DEPTH - 3);
  assign count_next = count + (bst_pkg::FIFO_AW + 1)'(added)
                      - (bst_pkg::FIFO_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (k < int'(added)) mem[wp + bst_pkg::FIFO_AW'(k)] <= push_toks[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + bst_pkg::FIFO_AW'(added);
      if (pop) rp <= rp + 1'b1;
      count <= count_next;
    end
  end

endmodule

>>> design/basic_source_tokenizer_core.sv
// ----------------------------------------------------------------------------
// basic_source_tokenizer_core
// Streaming source tokenizer: one byte in per cycle, tokens out via a queue.
// ----------------------------------------------------------------------------
// Tokens are registered into the queue as the byte completing them is accepted.
// Throughput: one byte in and one token out per cycle, each unless stalled.
// Input ready drops when the eight-entry token queue has fewer than three free.
// Reset (synchronous, active high) returns the scanner to idle at offset 0.
module basic_source_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_type,
  output logic [31:0] start_position,
  output logic [31:0] token_length,
  output logic signed [63:0] token_value,
  output logic        last_of_run
);

  logic           fire;
  logic [1:0]     tok_count;
  bst_pkg::tok_t  toks [3];
  bst_pkg::tok_t  out_tok;

  assign fire = in_valid && in_ready;

  bst_scan u_scan (
    .clk(clk), .rst(rst), .fire(fire), .kind(kind), .char_code(char_code),
    .tok_count(tok_count), .toks(toks)
  );

  bst_fifo u_fifo (
    .clk(clk), .rst(rst), .push(fire), .push_count(tok_count), .push_toks(toks),
    .room(in_ready), .out_valid(out_valid), .out_ready(out_ready), .out_tok(out_tok)
  );

  assign token_type = out_tok.ttype;
  assign start_position = out_tok.start;
  assign token_length = out_tok.len;
  assign token_value = out_tok.value;
  assign last_of_run = out_tok.last;

endmodule

>>> verif/basic_source_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_source_tokenizer_checker
// Watches both channels of the tokenizer, predicts the token stream for each
// accepted byte or end mark, and compares every accepted token field by field.
// ----------------------------------------------------------------------------
module basic_source_tokenizer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  char_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  token_type,
  input  logic [31:0] start_position,
  input  logic [31:0] token_length,
  input  logic [63:0] token_value,
  input  logic        last_of_run,
  output int          fail_count,
  output int          pending_tokens
);

  bst_pkg::tok_t  token_queue[$];
  bst_pkg::tok_t  step_tokens[$];
  bst_pkg::mode_t lx_mode;
  logic [31:0] lx_pos, lx_start;
  logic [63:0] lx_acc;
  logic [7:0]  lx_held;
  logic [3:0]  lx_flags;
  logic [1:0]  lx_radix;

  function automatic logic dig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic letr(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction
  function automatic logic alph(input logic [7:0] b);
    return letr(b) || b == "_" || b == "$";
  endfunction

  task automatic push_tok(input logic [3:0] t, input logic [31:0] s, input logic [31:0] l,
                          input logic [63:0] v);
    bst_pkg::tok_t r;
    r.ttype = t; r.start = s; r.len = l; r.value = v; r.last = 1'b0;
    if (step_tokens.size() < 3) step_tokens.push_back(r);
  endtask

  task automatic close_number(input logic [31:0] e);
    logic [31:0] l;
    l = e - lx_start;
    if (lx_flags[1]) push_tok(bst_pkg::TK_IMAG, lx_start, l, 0);
    else if (l >= 32'd64) push_tok(bst_pkg::TK_ERROR, lx_start, l, 0);
    else if (lx_flags[0]) push_tok(bst_pkg::TK_FLOAT, lx_start, l, 0);
    else push_tok(bst_pkg::TK_INT, lx_start, l, lx_acc);
    lx_mode = bst_pkg::M_IDLE;
  endtask

  task automatic close_held();
    push_tok(lx_held == ":" ? bst_pkg::TK_PUNCT : bst_pkg::TK_OP, lx_start, 1, 0);
    lx_mode = bst_pkg::M_IDLE;
  endtask

  task automatic clear_lexer();
    lx_mode = bst_pkg::M_IDLE; lx_pos = 0; lx_start = 0; lx_acc = 0;
    lx_held = 0; lx_flags = 0; lx_radix = 0;
  endtask

  task automatic scan_fresh(input logic [7:0] b, input logic [31:0] p);
    lx_start = p;
    if (b == " " || b == 8'h09 || b == 8'h0D) return;
    if (b == "&" || b == "<" || b == ">" || b == ":") begin
      lx_held = b; lx_mode = bst_pkg::M_HOLD;
    end else if (b == 8'h22) begin
      lx_start = p + 1; lx_mode = bst_pkg::M_STRING;
    end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "=" || b == "^" ||
                 b == 8'h5C || b == "|") begin
      push_tok(bst_pkg::TK_OP, p, 1, 0);
    end else if (b == "(" || b == ")" || b == "," || b == ";" || b == "#" || b == "@" ||
                 b == ".") begin
      push_tok(bst_pkg::TK_PUNCT, p, 1, 0);
    end else if (dig(b)) begin
      lx_acc = 64'(b - 8'h30); lx_flags = 0; lx_mode = bst_pkg::M_INT;
    end else if (alph(b)) begin
      lx_mode = bst_pkg::M_IDENT;
    end else begin
      push_tok(bst_pkg::TK_ERROR, p, 1, 0);
    end
  endtask

  task automatic number_char(input logic [7:0] b, input logic [31:0] p,
                             output logic again);
    logic [63:0] d;
    again = 1'b0;
    if (b == "i") begin
      lx_flags[1] = 1'b1; close_number(p + 1); return;
    end
    if (lx_mode == bst_pkg::M_INT) begin
      if (dig(b)) begin
        d = 64'(b - 8'h30);
        if (lx_acc > (bst_pkg::SAT_MAX - d) / 10) lx_acc = bst_pkg::SAT_MAX;
        else lx_acc = lx_acc * 10 + d;
        return;
      end
      if (b == ".") begin
        lx_held = b; lx_mode = bst_pkg::M_DOT; return;
      end
    end else if (lx_mode == bst_pkg::M_FRAC || lx_mode == bst_pkg::M_EXP1) begin
      if (dig(b)) return;
    end else begin
      if (dig(b) || b == "+" || b == "-") begin
        lx_mode = bst_pkg::M_EXP1; return;
      end
    end
    if ((lx_mode == bst_pkg::M_INT || lx_mode == bst_pkg::M_FRAC) &&
        (b == "E" || b == "e" || b == "D" || b == "d")) begin
      lx_flags[0] = 1'b1; lx_mode = bst_pkg::M_EXP0; return;
    end
    close_number(p);
    again = 1'b1;
  endtask

  task automatic lex_item(input logic k, input logic [7:0] b);
    logic [31:0] p, dotp;
    logic        again;
    logic [4:0]  rd;
    logic [63:0] r;
    p = lx_pos; again = 1'b0;
    step_tokens.delete();
    if (k) begin
      case (lx_mode)
        bst_pkg::M_HOLD:   close_held();
        bst_pkg::M_RADIX:  push_tok(bst_pkg::TK_INT, lx_start, p - lx_start, lx_acc);
        bst_pkg::M_STRING: push_tok(bst_pkg::TK_STRING, lx_start, p - lx_start, 0);
        bst_pkg::M_IDENT:  push_tok(bst_pkg::TK_IDENT, lx_start, p - lx_start, 0);
        bst_pkg::M_DOT: begin
          lx_flags[0] = 1'b1; close_number(p);
        end
        bst_pkg::M_INT, bst_pkg::M_FRAC, bst_pkg::M_EXP0, bst_pkg::M_EXP1: close_number(p);
        default: ;
      endcase
      push_tok(bst_pkg::TK_EOF, p, 0, 0);
      clear_lexer();
    end else begin
      case (lx_mode)
        bst_pkg::M_HOLD: begin
          if (lx_held == "&" && (b == "H" || b == "h" || b == "O" || b == "o" ||
                                 b == "B" || b == "b")) begin
            lx_radix = (b == "H" || b == "h") ? bst_pkg::RAD_HEX :
                       (b == "O" || b == "o") ? bst_pkg::RAD_OCT : bst_pkg::RAD_BIN;
            lx_acc = 0; lx_mode = bst_pkg::M_RADIX;
          end else if (((lx_held == "<" || lx_held == ">") && (b == "=" || b == ">")) ||
                       (lx_held == ":" && b == ":")) begin
            push_tok(bst_pkg::TK_OP, lx_start, 2, 0); lx_mode = bst_pkg::M_IDLE;
          end else begin
            close_held(); again = 1'b1;
          end
        end
        bst_pkg::M_RADIX: begin
          rd = 5'd0;
          if (lx_radix == bst_pkg::RAD_HEX) begin
            if (dig(b)) rd = {1'b1, 4'(b - 8'h30)};
            else if (b >= "A" && b <= "F") rd = {1'b1, 4'(b - 8'h37)};
            else if (b >= "a" && b <= "f") rd = {1'b1, 4'(b - 8'h57)};
          end else if (lx_radix == bst_pkg::RAD_OCT) begin
            if (b >= "0" && b <= "7") rd = {1'b1, 4'(b - 8'h30)};
          end else if (b == "0" || b == "1") begin
            rd = {1'b1, 4'(b - 8'h30)};
          end
          r = lx_radix == bst_pkg::RAD_HEX ? 64'd16 :
              lx_radix == bst_pkg::RAD_OCT ? 64'd8 : 64'd2;
          if (rd[4]) lx_acc = lx_acc * r + 64'(rd[3:0]);
          else begin
            push_tok(bst_pkg::TK_INT, lx_start, p - lx_start, lx_acc);
            lx_mode = bst_pkg::M_IDLE; again = 1'b1;
          end
        end
        bst_pkg::M_STRING: begin
          if (b == 8'h22 || b == 8'h0A) begin
            push_tok(bst_pkg::TK_STRING, lx_start, p - lx_start, 0);
            lx_mode = bst_pkg::M_IDLE; again = (b == 8'h0A);
          end
        end
        bst_pkg::M_IDENT: begin
          if (!(alph(b) || dig(b))) begin
            if (b == "$" || b == "%" || b == "&" || b == "!" || b == "#" || b == "~") begin
              push_tok(bst_pkg::TK_IDENT, lx_start, p + 1 - lx_start, 0);
            end else begin
              push_tok(bst_pkg::TK_IDENT, lx_start, p - lx_start, 0); again = 1'b1;
            end
            lx_mode = bst_pkg::M_IDLE;
          end
        end
        bst_pkg::M_DOT: begin
          dotp = p - 1;
          if (letr(b)) begin
            close_number(dotp); push_tok(bst_pkg::TK_PUNCT, dotp, 1, 0); again = 1'b1;
          end else begin
            lx_flags[0] = 1'b1; lx_mode = bst_pkg::M_FRAC; number_char(b, p, again);
          end
        end
        bst_pkg::M_INT, bst_pkg::M_FRAC, bst_pkg::M_EXP0, bst_pkg::M_EXP1:
          number_char(b, p, again);
        default: again = 1'b1;
      endcase
      if (again) scan_fresh(b, p);
      lx_pos = p + 1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
  endtask

  always @(posedge clk) begin
    bst_pkg::tok_t e;
    if (rst) begin
      clear_lexer();
      token_queue.delete();
      fail_count <= 0;
      pending_tokens <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (token_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected token type %0d at %0d", token_type,
                                        start_position);
          fail_count <= fail_count + 1;
        end else begin
          e = token_queue.pop_front();
          if (e.ttype !== token_type || e.start !== start_position ||
              e.len !== token_length || e.value !== token_value ||
              e.last !== last_of_run) begin
            if (fail_count < 10)
              $display("mismatch exp t%0d s%0d l%0d v%0d e%0b got t%0d s%0d l%0d v%0d e%0b",
                       e.ttype, e.start, e.len, e.value, e.last, token_type,
                       start_position, token_length, token_value, last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) lex_item(kind, char_code);
      pending_tokens <= token_queue.size();
    end
  end

endmodule

>>> verif/basic_source_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_source_tokenizer_core_tb
// Drives directed and random source text with random gaps and stalls into the
// tokenizer; a checker beside it predicts and compares the token stream.
// ----------------------------------------------------------------------------
module basic_source_tokenizer_core_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [7:0]  char_code = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  token_type;
  logic [31:0] start_position, token_length;
  logic signed [63:0] token_value;
  logic        last_of_run;
  int          fail_count, pending_tokens;
  logic        hold_off = 1'b0;
  int          idle_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  basic_source_tokenizer_core dut (.*);

  basic_source_tokenizer_checker checker_i (.*);

  task automatic send(input logic k, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; kind <= k; char_code <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_tokens == 0);
    @(posedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send(1'b0, s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic send_phrase();
    int n;
    n = $urandom_range(0, 11);
    case (n)
      0: repeat ($urandom_range(1, 6)) send(1'b0, pick("0123456789"));
      1: begin
        send_text("&"); send(1'b0, pick("HhOoBb"));
        repeat ($urandom_range(0, 5)) send(1'b0, pick("0123456789abcdefABCDEFg"));
      end
      2: begin
        send(1'b0, pick("123")); send_text(".");
        repeat ($urandom_range(0, 3)) send(1'b0, pick("0123456789"));
        if ($urandom_range(0, 1)) begin
          send(1'b0, pick("EeDd")); send(1'b0, pick("+-5")); send(1'b0, pick("27"));
        end
        if ($urandom_range(0, 1)) send_text("i");
      end
      3: begin
        send(1'b0, 8'h22);
        repeat ($urandom_range(0, 4)) send(1'b0, pick("ab 1+"));
        send(1'b0, $urandom_range(0, 3) == 0 ? 8'h0A : 8'h22);
      end
      4: begin
        send(1'b0, pick("abXyz_"));
        repeat ($urandom_range(0, 3)) send(1'b0, pick("a9_$Q"));
        if ($urandom_range(0, 1)) send(1'b0, pick("$%&!#~"));
      end
      5: begin
        send(1'b0, pick("<>:&")); send(1'b0, pick("=>:<1a "));
      end
      6: send(1'b0, pick("+-*/=^\\|(),;#@. \t\r"));
      7: begin
        send(1'b0, pick("45")); send_text("."); send(1'b0, pick("xE"));
      end
      8: send(1'b0, 8'($urandom_range(0, 255)));
      9: send(1'b0, 8'($urandom_range(128, 255)));
      10: send(1'b1, 8'($urandom_range(0, 255)));
      default: send_text(" ");
    endcase
  endtask

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_text("9223372036854775808 &HFFFFFFFFFFFFFFFFF &B &o17 ");
    send_text("1.x 2. ");
    send(1'b1, 8'd0);
    send_text("3.5e+2i \"ab"); send(1'b0, 8'h0A);
    send_text("<>:: a$ b% <"); send(1'b1, 8'hFF);
    send_text("1234567890123456789012345678901234567890123456789012345678901234 ");
    send_text("7. ="); send(1'b0, 8'h00); send(1'b0, 8'hFF);
    send_text("\"open"); send(1'b1, 8'd0);
    send_text("1."); send(1'b1, 8'd0);
    fork
      begin
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
      end
      repeat (20) send_text("+");
    join
    drain();
    k = 0;
    while (k < 40) begin
      send_phrase();
      k++;
      if (k == 20) drain();
    end
    send(1'b1, 8'd0);
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_tokens == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
design/bst_pkg.sv
design/bst_scan.sv
design/bst_fifo.sv
design/basic_source_tokenizer_core.sv
verif/basic_source_tokenizer_checker.sv
verif/basic_source_tokenizer_core_tb.sv
